>>> src/assert_macros.svh
// Assertion macros shared by the cache tag store RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/lsac_pkg.sv
// Shared types and constants of the set-associative cache tag store.
// No dependencies; used by the channel interfaces and the top level.
package lsac_pkg;

	localparam int DEF_SET_BITS       = 1;
	localparam int DEF_WAY_BITS       = 2;
	localparam int DEF_LINE_WORD_BITS = 4;
	localparam int DEF_PENDING_DEPTH  = 16;

	localparam int ADDR_W     = 32;
	localparam int TIME_W     = 31;
	localparam int BYTE_BITS  = 2;
	localparam int FILL_WAY_W = 2;
	localparam int COUNT_W    = 5;

	localparam logic FN_LOOKUP = 1'b0;
	localparam logic FN_FILL   = 1'b1;

	typedef enum logic [2:0] {
		ST_HIT    = 3'd0,
		ST_ISSUED = 3'd1,
		ST_MERGED = 3'd2,
		ST_FULL   = 3'd3,
		ST_FILL   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_WRD,
		S_WCHK,
		S_PRD,
		S_PCHK,
		S_FIN
	} state_t;

endpackage

>>> src/lsac_if.sv
// Request and response channel interfaces of the cache tag store.
// Depends on lsac_pkg for field widths and the status type.
interface lsac_req_if import lsac_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [ADDR_W-1:0]     address;
	logic [FILL_WAY_W-1:0] fill_way;
	logic [TIME_W-1:0]     timestamp;

	modport source (output valid, func, address, fill_way, timestamp, input ready);
	modport sink (input valid, func, address, fill_way, timestamp, output ready);
endinterface

interface lsac_rsp_if import lsac_pkg::*; ();
	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [FILL_WAY_W-1:0] victim_way;
	logic                  evicted;
	logic [COUNT_W-1:0]    pending_count;

	modport source (output valid, status, victim_way, evicted, pending_count, input ready);
	modport sink (input valid, status, victim_way, evicted, pending_count, output ready);
endinterface

>>> src/lru_set_assoc_cache_with_miss_merge_unit.sv
// Tag store of a set-associative cache with timestamp LRU and an outstanding-miss list.
// Depends on lsac_pkg, the channel interfaces in lsac_if.sv and assert_macros.svh.
//
// Usage: the req channel carries lookups (func 0) and fills returning from memory (func 1).
// Every request beat yields exactly one rsp beat with status, victim way, evicted flag and
// the number of outstanding misses after the request.
// One sequencer walks the ways of the addressed set (lookups only) and then the pending
// list, one entry at a time, through a line memory and a pending memory, each with one
// read and one write port, and one shared equality comparator. A lookup reads and checks
// each way in turn (S_WRD, S_WCHK) and ends at the first hit; on a miss it then scans
// the pending slots in turn (S_PRD, S_PCHK), at most PENDING_DEPTH of them, stopping at
// a match. A fill writes its line (S_FILL) and then scans the pending list the same way;
// every request ends in S_FIN. req.ready is high only while the sequencer is idle, which
// it reaches as the result is loaded, so the block takes no new request beat before the
// previous result has been loaded into the response register.
// Reset clears all line valid bits, all pending slots and the response valid bit; tags,
// times and pending addresses are undefined until written and are never used before.
// When the receiver stalls, the finished result holds in the response register and the
// sequencer waits at its last step; the pending list update and the victim invalidation
// are committed only when the response register takes the new result.
`include "assert_macros.svh"

module lru_set_assoc_cache_with_miss_merge_unit import lsac_pkg::*; #(
	parameter int SET_BITS       = DEF_SET_BITS,
	parameter int WAY_BITS       = DEF_WAY_BITS,
	parameter int LINE_WORD_BITS = DEF_LINE_WORD_BITS,
	parameter int PENDING_DEPTH  = DEF_PENDING_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lsac_req_if.sink   req,
	lsac_rsp_if.source rsp
);

	localparam int OFFSET_BITS = LINE_WORD_BITS + BYTE_BITS;
	localparam int TAG_W       = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int SET_W       = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int W_W         = (WAY_BITS > 0) ? WAY_BITS : 1;
	localparam int NUM_WAYS    = 1 << WAY_BITS;
	localparam int NUM_LINES   = 1 << (SET_BITS + WAY_BITS);
	localparam int LIDX_W      = ((SET_BITS + WAY_BITS) > 0) ? (SET_BITS + WAY_BITS) : 1;
	localparam int P_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int C_W         = $clog2(PENDING_DEPTH + 1);
	localparam int LINE_W      = TAG_W + TIME_W;

	localparam logic [W_W-1:0] WAY_MASK = W_W'(NUM_WAYS - 1);
	localparam logic [P_W-1:0] P_LAST   = P_W'(PENDING_DEPTH - 1);

	function automatic logic [LIDX_W-1:0] line_idx(input logic [SET_W-1:0] set_i,
		input logic [W_W-1:0] way_i);
		line_idx = (LIDX_W'(set_i) << WAY_BITS) | LIDX_W'(way_i);
	endfunction

	state_t state_q, state_d;

	// Latched request.
	logic              func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [W_W-1:0]    fway_q;
	logic [TIME_W-1:0] now_q;

	// Scan state.
	logic [W_W-1:0]    w_q;
	logic [W_W-1:0]    victim_q;
	logic              any_inv_q;
	logic              have_valid_q;
	logic [TIME_W-1:0] best_q;
	logic              hit_q;
	logic [P_W-1:0]    p_q;
	logic              found_q;
	logic [P_W-1:0]    found_idx_q;
	logic              free_found_q;
	logic [P_W-1:0]    free_idx_q;

	// Stored state kept in flip-flops.
	logic [NUM_LINES-1:0]     valid_q;
	logic [PENDING_DEPTH-1:0] used_q;
	logic [C_W-1:0]           cnt_q;

	// Memories.
	logic [LINE_W-1:0] lmem [NUM_LINES];
	logic [ADDR_W-1:0] pmem [PENDING_DEPTH];
	logic [LINE_W-1:0] lm_rd_q;
	logic [ADDR_W-1:0] pm_rd_q;
	logic              lm_we;
	logic [LIDX_W-1:0] lm_wa;
	logic              pm_we;

	// Response register.
	logic                  out_valid_q;
	status_t               status_q;
	logic [FILL_WAY_W-1:0] victim_out_q;
	logic                  evicted_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic              accept;
	logic              out_free;
	logic              ld_out;
	logic [TAG_W-1:0]  tag_c;
	logic [SET_W-1:0]  set_c;
	logic [LIDX_W-1:0] lidx_scan;
	logic [LIDX_W-1:0] lidx_fill;
	logic [LIDX_W-1:0] lidx_victim;
	logic [TAG_W-1:0]  rtag;
	logic [TIME_W-1:0] rtime;
	logic [ADDR_W-1:0] cmp_a;
	logic [ADDR_W-1:0] cmp_b;
	logic              cmp_eq;
	logic              way_hit;
	logic              pend_hit;
	status_t           res_status;
	logic [C_W-1:0]    cnt_next;
	logic              res_evicted;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	assign tag_c       = addr_q[ADDR_W-1 -: TAG_W];
	assign set_c       = (SET_BITS == 0) ? '0 : addr_q[OFFSET_BITS +: SET_W];
	assign lidx_scan   = line_idx(set_c, w_q);
	assign lidx_fill   = line_idx(set_c, fway_q);
	assign lidx_victim = line_idx(set_c, victim_q);

	assign rtag  = lm_rd_q[TIME_W +: TAG_W];
	assign rtime = lm_rd_q[TIME_W-1:0];

	// One equality comparator serves both the tag check and the pending address check.
	assign cmp_a    = (state_q == S_PCHK) ? pm_rd_q : ADDR_W'(rtag);
	assign cmp_b    = (state_q == S_PCHK) ? addr_q : ADDR_W'(tag_c);
	assign cmp_eq   = (cmp_a == cmp_b);
	assign way_hit  = valid_q[lidx_scan] && cmp_eq;
	assign pend_hit = used_q[p_q] && cmp_eq;

	always_comb begin
		if (func_q == FN_FILL) begin
			res_status = ST_FILL;
		end else if (hit_q) begin
			res_status = ST_HIT;
		end else if (found_q) begin
			res_status = ST_MERGED;
		end else if (!free_found_q) begin
			res_status = ST_FULL;
		end else begin
			res_status = ST_ISSUED;
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		if (res_status == ST_ISSUED) begin
			cnt_next = cnt_q + C_W'(1);
		end else if (res_status == ST_FILL && found_q) begin
			cnt_next = cnt_q - C_W'(1);
		end
	end

	assign res_evicted = (res_status == ST_ISSUED) && valid_q[lidx_victim];

	always_comb begin
		state_d = state_q;
		lm_we   = 1'b0;
		lm_wa   = lidx_scan;
		ld_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (req.func == FN_FILL) ? S_FILL : S_WRD;
				end
			end
			S_FILL: begin
				lm_we   = 1'b1;
				lm_wa   = lidx_fill;
				state_d = S_PRD;
			end
			S_WRD: begin
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (way_hit) begin
					// Refresh the hitting line's time; its tag is the lookup tag.
					lm_we   = 1'b1;
					state_d = S_FIN;
				end else if (w_q == WAY_MASK) begin
					state_d = S_PRD;
				end else begin
					state_d = S_WRD;
				end
			end
			S_PRD: begin
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (pend_hit || p_q == P_LAST) begin
					state_d = S_FIN;
				end else begin
					state_d = S_PRD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign pm_we = ld_out && (res_status == ST_ISSUED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q          <= '0;
			victim_q     <= '0;
			any_inv_q    <= 1'b0;
			have_valid_q <= 1'b0;
			hit_q        <= 1'b0;
			p_q          <= '0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			used_q       <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				w_q          <= '0;
				any_inv_q    <= 1'b0;
				have_valid_q <= 1'b0;
				hit_q        <= 1'b0;
				p_q          <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == S_FILL) begin
				valid_q[lidx_fill] <= 1'b1;
			end
			if (state_q == S_WCHK) begin
				if (way_hit) begin
					hit_q <= 1'b1;
				end else if (!valid_q[lidx_scan]) begin
					// The last invalid way wins over any valid one.
					any_inv_q <= 1'b1;
					victim_q  <= w_q;
				end else if (!any_inv_q && (!have_valid_q || rtime < best_q)) begin
					have_valid_q <= 1'b1;
					victim_q     <= w_q;
				end
				w_q <= w_q + W_W'(1);
			end
			if (state_q == S_PCHK) begin
				if (pend_hit) begin
					found_q     <= 1'b1;
					found_idx_q <= p_q;
				end else if (!used_q[p_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= p_q;
				end
				p_q <= p_q + P_W'(1);
			end
			if (ld_out) begin
				if (res_status == ST_ISSUED) begin
					used_q[free_idx_q]   <= 1'b1;
					valid_q[lidx_victim] <= 1'b0;
				end else if (res_status == ST_FILL && found_q) begin
					used_q[found_idx_q] <= 1'b0;
				end
				cnt_q <= cnt_next;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			addr_q <= req.address;
			fway_q <= W_W'(req.fill_way) & WAY_MASK;
			now_q  <= req.timestamp;
		end
		if (state_q == S_WCHK && !way_hit && valid_q[lidx_scan] && !any_inv_q
			&& (!have_valid_q || rtime < best_q)) begin
			best_q <= rtime;
		end
		if (ld_out) begin
			status_q     <= res_status;
			victim_out_q <= (res_status == ST_ISSUED) ? FILL_WAY_W'(victim_q) : '0;
			evicted_q    <= res_evicted;
			count_out_q  <= COUNT_W'(cnt_next);
		end
	end

	// Line memory: tag and last access time, one read and one write port.
	always_ff @(posedge clk) begin
		if (lm_we) begin
			lmem[lm_wa] <= {tag_c, now_q};
		end
		lm_rd_q <= lmem[lidx_scan];
	end

	// Pending address memory.
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pmem[free_idx_q] <= addr_q;
		end
		pm_rd_q <= pmem[p_q];
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.victim_way    = victim_out_q;
	assign rsp.evicted       = evicted_q;
	assign rsp.pending_count = count_out_q;

	`ASSERT_ALWAYS(a_cnt_matches_used, cnt_q == C_W'($countones(used_q)))
	`ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE)
	`ASSERT_NEXT(a_issue_grows_list, ld_out && res_status == ST_ISSUED,
		cnt_q == $past(cnt_q) + C_W'(1))
	`ASSERT_SAME(a_full_no_free, ld_out && res_status == ST_FULL, used_q == '1)
	`ASSERT_NEXT(a_issue_clears_victim, ld_out && res_status == ST_ISSUED,
		!valid_q[$past(lidx_victim)])

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the cache tag store with LRU replacement and outstanding-miss merging.
// Depends on lsac_pkg, the channel interfaces in lsac_if.sv and the top level under src.
module tb;
	import lsac_pkg::*;

	localparam int SETS      = 1 << DEF_SET_BITS;
	localparam int WAYS      = 1 << DEF_WAY_BITS;
	localparam int OFF_BITS  = DEF_LINE_WORD_BITS + BYTE_BITS;
	localparam int TAG_W     = ADDR_W - DEF_SET_BITS - OFF_BITS;
	localparam int MSHR_N    = DEF_PENDING_DEPTH;
	localparam int PER_PHASE = 358;
	localparam int POOL_N    = 24;
	localparam int CYCLE_CAP = 1000000;

	typedef struct packed {
		logic                  func;
		logic [ADDR_W-1:0]     address;
		logic [FILL_WAY_W-1:0] fill_way;
		logic [TIME_W-1:0]     timestamp;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [FILL_WAY_W-1:0] victim_way;
		logic                  evicted;
		logic [COUNT_W-1:0]    pending_count;
	} rsp_t;

	typedef struct packed {
		req_t req;
		logic typed;
		rsp_t result;
	} dir_row_t;

	localparam rsp_t UNTYPED = '{ST_HIT, 2'd0, 1'b0, 5'd0};

	// Opening sequence: merging, hit over pending, fills of absent addresses, LRU ties.
	dir_row_t directed [19] = '{
		'{'{FN_LOOKUP, 32'h0000_0000, 2'd0, 31'd5}, 1'b1, '{ST_ISSUED, 2'd3, 1'b0, 5'd1}},
		'{'{FN_LOOKUP, 32'h0000_0000, 2'd0, 31'd6}, 1'b1, '{ST_MERGED, 2'd0, 1'b0, 5'd1}},
		'{'{FN_LOOKUP, 32'h0000_0004, 2'd0, 31'd6}, 1'b1, '{ST_ISSUED, 2'd3, 1'b0, 5'd2}},
		'{'{FN_FILL,   32'h0000_0000, 2'd3, 31'd7}, 1'b1, '{ST_FILL, 2'd0, 1'b0, 5'd1}},
		'{'{FN_LOOKUP, 32'h0000_003C, 2'd0, 31'd8}, 1'b1, '{ST_HIT, 2'd0, 1'b0, 5'd1}},
		'{'{FN_FILL,   32'h0000_0004, 2'd2, 31'd9}, 1'b1, '{ST_FILL, 2'd0, 1'b0, 5'd0}},
		'{'{FN_FILL,   32'hFFFF_FFFF, 2'd0, 31'h7FFF_FFFF}, 1'b1, '{ST_FILL, 2'd0, 1'b0, 5'd0}},
		'{'{FN_LOOKUP, 32'hFFFF_FFC0, 2'd0, 31'd0}, 1'b1, '{ST_HIT, 2'd0, 1'b0, 5'd0}},
		'{'{FN_FILL,   32'h0000_0080, 2'd0, 31'h7FFF_FFFF}, 1'b0, UNTYPED},
		'{'{FN_FILL,   32'h0000_0100, 2'd1, 31'h7FFF_FFFF}, 1'b0, UNTYPED},
		'{'{FN_LOOKUP, 32'h0000_0000, 2'd0, 31'h7FFF_FFFF}, 1'b0, UNTYPED},
		'{'{FN_LOOKUP, 32'h0000_0180, 2'd0, 31'd3}, 1'b0, UNTYPED},
		'{'{FN_FILL,   32'h0000_0180, 2'd3, 31'h7FFF_FFFF}, 1'b0, UNTYPED},
		'{'{FN_LOOKUP, 32'h0000_0200, 2'd0, 31'd1}, 1'b0, UNTYPED},
		'{'{FN_FILL,   32'h0000_0200, 2'd1, 31'd4}, 1'b0, UNTYPED},
		'{'{FN_LOOKUP, 32'h0000_0100, 2'd0, 31'd5}, 1'b0, UNTYPED},
		'{'{FN_FILL,   32'h1234_5678, 2'd3, 31'd6}, 1'b0, UNTYPED},
		'{'{FN_LOOKUP, 32'hFFFF_FFFF, 2'd0, 31'd7}, 1'b0, UNTYPED},
		'{'{FN_FILL,   32'h0000_0100, 2'd0, 31'd0}, 1'b0, UNTYPED}
	};

	int idle_mix [4][2] = '{'{0, 0}, '{71, 0}, '{0, 71}, '{9, 9}};

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   stall_pct;
	int   mismatches;
	int   cycles;

	// Mirror of the tag store and the miss list, plus the victim recorded for each miss.
	logic                  line_valid [SETS*WAYS];
	logic [TAG_W-1:0]      line_tag   [SETS*WAYS];
	logic [TIME_W-1:0]     line_time  [SETS*WAYS];
	logic [ADDR_W-1:0]     miss_addr  [MSHR_N];
	logic                  miss_used  [MSHR_N];
	logic [FILL_WAY_W-1:0] miss_way   [MSHR_N];

	logic [ADDR_W-1:0] addr_pool [POOL_N];
	logic [TIME_W-1:0] now_ts;
	rsp_t              expected_rsps [$];

	lsac_req_if req_ch ();
	lsac_rsp_if rsp_ch ();

	lru_set_assoc_cache_with_miss_merge_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic rsp_t tag_store_access(req_t q);
		rsp_t             r;
		int               base;
		int               free_slot;
		int               pend_hit;
		int               n;
		int               fway;
		int               victim;
		logic [TAG_W-1:0] tag;
		logic             hit;
		logic             any_invalid;
		logic             have_valid;
		logic [TIME_W-1:0] oldest;
		r = UNTYPED;
		tag = TAG_W'(q.address >> (OFF_BITS + DEF_SET_BITS));
		base = int'((q.address >> OFF_BITS) & (SETS - 1)) * WAYS;
		free_slot = -1;
		pend_hit = -1;
		for (int i = 0; i < MSHR_N; i++) begin
			if (miss_used[i] && miss_addr[i] == q.address && pend_hit < 0)
				pend_hit = i;
			if (!miss_used[i] && free_slot < 0)
				free_slot = i;
		end
		if (q.func == FN_FILL) begin
			fway = int'(q.fill_way) & (WAYS - 1);
			line_valid[base + fway] = 1'b1;
			line_tag[base + fway] = tag;
			line_time[base + fway] = q.timestamp;
			if (pend_hit >= 0)
				miss_used[pend_hit] = 1'b0;
			r.status = ST_FILL;
		end else begin
			hit = 1'b0;
			for (int w = 0; w < WAYS; w++) begin
				if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
					line_time[base + w] = q.timestamp;
					hit = 1'b1;
				end
			end
			if (hit)
				r.status = ST_HIT;
			else if (pend_hit >= 0)
				r.status = ST_MERGED;
			else if (free_slot < 0)
				r.status = ST_FULL;
			else begin
				miss_addr[free_slot] = q.address;
				miss_used[free_slot] = 1'b1;
				any_invalid = 1'b0;
				have_valid = 1'b0;
				oldest = '0;
				victim = 0;
				// The last invalid way wins; otherwise the oldest valid way, first on ties.
				for (int w = 0; w < WAYS; w++) begin
					if (!line_valid[base + w]) begin
						any_invalid = 1'b1;
						victim = w;
					end else if (!any_invalid && (!have_valid || line_time[base + w] < oldest)) begin
						have_valid = 1'b1;
						oldest = line_time[base + w];
						victim = w;
					end
				end
				r.victim_way = FILL_WAY_W'(victim);
				r.evicted = line_valid[base + victim];
				line_valid[base + victim] = 1'b0;
				miss_way[free_slot] = FILL_WAY_W'(victim);
				r.status = ST_ISSUED;
			end
		end
		n = 0;
		for (int i = 0; i < MSHR_N; i++)
			if (miss_used[i])
				n++;
		r.pending_count = COUNT_W'(n);
		return r;
	endfunction

	// A handful of tags across both sets keeps lines competing for ways and addresses repeating.
	task automatic refill_address_pool();
		logic [TAG_W-1:0] tags [6];
		foreach (tags[k]) begin
			case ($urandom_range(0, 9))
				0:       tags[k] = '0;
				1:       tags[k] = '1;
				default: tags[k] = TAG_W'($urandom);
			endcase
		end
		foreach (addr_pool[i])
			addr_pool[i] = {tags[$urandom_range(0, 5)], DEF_SET_BITS'($urandom), OFF_BITS'($urandom)};
	endtask

	function automatic req_t next_random_request(int fill_pct);
		req_t q;
		int   live [$];
		int   pick;
		int   s;
		case ($urandom_range(0, 99))
			0, 1, 2: now_ts = TIME_W'($urandom);
			3, 4:    now_ts = '1;
			5:       now_ts = '0;
			default: now_ts = now_ts + TIME_W'($urandom_range(0, 3));
		endcase
		q.timestamp = now_ts;
		q.fill_way = '0;
		foreach (miss_used[i])
			if (miss_used[i])
				live.push_back(i);
		pick = $urandom_range(0, 99);
		if (pick < fill_pct && live.size() > 0) begin
			s = live[$urandom_range(0, live.size() - 1)];
			q.func = FN_FILL;
			q.address = miss_addr[s];
			q.fill_way = miss_way[s];
		end else if (pick < 92) begin
			q.func = FN_LOOKUP;
			q.address = addr_pool[$urandom_range(0, POOL_N - 1)];
		end else if (pick < 96) begin
			q.func = FN_LOOKUP;
			q.address = $urandom;
		end else begin
			q.func = FN_FILL;
			q.address = pick[0] ? $urandom : addr_pool[$urandom_range(0, POOL_N - 1)];
			q.fill_way = FILL_WAY_W'($urandom);
		end
		return q;
	endfunction

	// Returns at the edge where the beat is taken; the caller drives the next one in that step.
	task automatic send_request(req_t q);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.func      <= q.func;
		req_ch.address   <= q.address;
		req_ch.fill_way  <= q.fill_way;
		req_ch.timestamp <= q.timestamp;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin : response_check
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: response beat with nothing expected, status %0d count %0d",
					$time, rsp_ch.status, rsp_ch.pending_count);
				mismatches++;
			end else begin
				want = expected_rsps.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_ch.status));
				check_field("victim_way", 32'(want.victim_way), 32'(rsp_ch.victim_way));
				check_field("evicted", 32'(want.evicted), 32'(rsp_ch.evicted));
				check_field("pending_count", 32'(want.pending_count),
					32'(rsp_ch.pending_count));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		req_t item;
		rsp_t want;
		int   fill_pct;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_LOOKUP;
		req_ch.address = '0;
		req_ch.fill_way = '0;
		req_ch.timestamp = '0;
		src_idle_pct = 0;
		stall_pct = 0;
		now_ts = '0;
		fill_pct = 30;
		foreach (line_valid[i]) line_valid[i] = 1'b0;
		foreach (miss_used[i]) miss_used[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			item = directed[i].req;
			send_request(item);
			want = tag_store_access(item);
			expected_rsps.push_back(directed[i].typed ? directed[i].result : want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_mix[ph][0];
			stall_pct = idle_mix[ph][1];
			for (int n = 0; n < PER_PHASE; n++) begin
				if (n % 100 == 0)
					refill_address_pool();
				// Low fill rates let the miss list run full; high ones drain it.
				if (n % 60 == 0)
					case ($urandom_range(0, 2))
						0:       fill_pct = 5;
						1:       fill_pct = 30;
						default: fill_pct = 50;
					endcase
				item = next_random_request(fill_pct);
				send_request(item);
				expected_rsps.push_back(tag_store_access(item));
			end
		end
		req_ch.valid <= 1'b0;

		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
